@@ src/fcwt_pkg.sv @@
// ----------------------------------------------------------------------------
// fcwt_pkg
// Shared types and constants of the flow cache with timeouts.
// ----------------------------------------------------------------------------
package fcwt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TIME_BITS     = 32;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

    // Layout of one memory word: key, ports, marks, start, last, packets, bytes.
    localparam int KEY_BITS   = 72;
    localparam int WORD_BITS  = KEY_BITS + 32 + 7 + TIME_BITS + TIME_BITS + 32 + 48;

    localparam int IN_TDATA_BITS  = 128;
    localparam int OUT_TDATA_BITS = 256;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_SCTP = 8'd132;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_IDLE   = 2'd1;
    localparam logic [1:0] REG_ACTIVE = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic STATUS_EXPORT = 1'b0;
    localparam logic STATUS_DROP   = 1'b1;

    typedef struct packed {
        logic [47:0]          bytes;
        logic [31:0]          packets;
        logic [TIME_BITS-1:0] last;
        logic [TIME_BITS-1:0] start;
        logic [6:0]           marks;
        logic [31:0]          ports;
        logic [KEY_BITS-1:0]  key;
    } entry_t;

endpackage

@@ src/fcwt_ram.sv @@
// ----------------------------------------------------------------------------
// fcwt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/flow_cache_with_timeouts.sv @@
// ----------------------------------------------------------------------------
// flow_cache_with_timeouts
// Flow table with idle and active timeouts, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries packet and tick items (tuser = kind). A
// packet item looks its key up in the table and either updates the matching
// entry, opens a new one in the lowest free slot, or, when the table is full,
// produces one drop record (status 1). A tick item advances the time counter
// and exports every entry whose idle or active deadline has been reached, in
// ascending entry order; tlast marks the last record caused by an item.
// Configuration (enable, idle and active timeouts) must be written on the cfg
// channel only while the block is idle; the block itself does not enforce it.
// Timing: one item is handled at a time. Every tick and every enabled packet
// sweeps the whole table through the RAM read port, one entry per cycle while
// the sweep is not stalled, followed by a decide state. A disabled packet
// starts no sweep and leaves the table unchanged. Each export record is
// held back until the sweep finds the next one or ends, so that tlast can be
// set; the last record of a tick goes to the output register from ST_DECIDE.
// Reset clears the valid bits (flip-flops), the time counter and the control
// registers; the RAM itself needs no clearing. When m_tready is low the sweep
// pauses at an expiring entry while one record is held and another waits at
// the output, and s_tready stays low until the last record has been taken.
// ----------------------------------------------------------------------------
module flow_cache_with_timeouts
    import fcwt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata: src_ip, dst_ip, protocol, src_port, dst_port, byte_length,
    //        tcp_flags, threat_mark (from bit 0 up), zero padded
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // tuser: kind
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata: flow_src_ip, flow_dst_ip, flow_protocol, flow_src_port,
    //        flow_dst_port, first_tick, last_tick, packets, bytes, marks
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    // tuser: status
    output logic                      m_tuser,
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_WRITE
    } state_t;

    state_t                state_reg;
    logic                  enable_reg;
    logic [15:0]           idle_reg, active_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // Item latched at acceptance.
    logic                  kind_reg;
    logic [31:0]           src_reg, dst_reg;
    logic [7:0]            proto_reg;
    logic [31:0]           ports_reg;
    logic [6:0]            marks_reg;
    logic [15:0]           len_reg;

    // Sweep: rd address issued, then data for the previous address.
    logic [CNT_BITS-1:0]   rd_cnt_reg;     // next address to read
    logic                  rd_pend_reg;    // data in flight for chk_idx_reg
    logic [IDX_BITS-1:0]   chk_idx_reg;
    logic                  hit_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic                  free_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic                  exp_any_reg;    // an export record is held back
    entry_t                exp_ent_reg;    // the held export record
    entry_t                hit_ent_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [OUT_TDATA_BITS-1:0] m_data_reg;
    logic                  m_user_reg, m_last_reg;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_wa, ram_ra;
    entry_t                ram_wd, ram_rd;

    fcwt_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_ENTRIES)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;

    // Checks on the entry returned by the RAM.
    logic [TIME_BITS-1:0] idle_age, active_age;
    logic                 rd_valid, rd_match, rd_expire;
    logic                 more_reads;
    logic [CNT_BITS-1:0]  last_cnt;

    assign last_cnt   = CNT_BITS'(TABLE_ENTRIES);
    assign more_reads = rd_cnt_reg != last_cnt;
    assign rd_valid   = rd_pend_reg && valid_reg[chk_idx_reg];
    assign idle_age   = now_reg - ram_rd.last;
    assign active_age = now_reg - ram_rd.start;
    assign rd_match   = rd_valid && (ram_rd.key == {proto_reg, dst_reg, src_reg});
    assign rd_expire  = rd_valid &&
                        ((idle_age >= TIME_BITS'(idle_reg)) ||
                         (active_age >= TIME_BITS'(active_reg)));

    // The output register can take a record at the next edge.
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // A tick sweep stalls when a new expiring entry needs the held record
    // pushed out while the output is still occupied.
    logic stall;
    assign stall = (state_reg == ST_SCAN) && (kind_reg == KIND_TICK) &&
                   rd_expire && exp_any_reg && !out_free;

    // While stalled, the entry under check is read again so its data holds.
    assign ram_ra = stall ? chk_idx_reg : rd_cnt_reg[IDX_BITS-1:0];

    function automatic logic [OUT_TDATA_BITS-1:0] pack_rec(input entry_t e);
        pack_rec = OUT_TDATA_BITS'({e.marks, e.bytes, e.packets, 32'(e.last),
                                    32'(e.start), e.ports[15:0], e.ports[31:16],
                                    e.key});
    endfunction

    // Saturating update of a hit entry.
    entry_t upd;
    always_comb begin
        upd      = hit_ent_reg;
        upd.last = now_reg;
        if (hit_ent_reg.packets != 32'hFFFF_FFFF) begin
            upd.packets = hit_ent_reg.packets + 32'd1;
        end
        if ({1'b0, hit_ent_reg.bytes} + 49'(len_reg) > 49'h0FFFF_FFFF_FFFF) begin
            upd.bytes = 48'hFFFF_FFFF_FFFF;
        end else begin
            upd.bytes = hit_ent_reg.bytes + 48'(len_reg);
        end
    end

    entry_t newent;
    always_comb begin
        newent.key     = {proto_reg, dst_reg, src_reg};
        newent.ports   = ports_reg;
        newent.marks   = marks_reg;
        newent.start   = now_reg;
        newent.last    = now_reg;
        newent.packets = 32'd1;
        newent.bytes   = 48'(len_reg);
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wa = hit_idx_reg;
        ram_wd = upd;
        if (state_reg == ST_WRITE) begin
            ram_we = 1'b1;
            if (!hit_reg) begin
                ram_wa = free_idx_reg;
                ram_wd = newent;
            end
        end
    end

    logic in_acc;
    logic [7:0] in_proto;
    assign in_acc   = s_tvalid && s_tready;
    assign in_proto = s_tdata[71:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b0;
            idle_reg    <= '0;
            active_reg  <= '0;
            now_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            exp_any_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_IDLE:   idle_reg   <= cfg_data[15:0];
                    REG_ACTIVE: active_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        kind_reg  <= s_tuser;
                        src_reg   <= s_tdata[31:0];
                        dst_reg   <= s_tdata[63:32];
                        proto_reg <= in_proto;
                        len_reg   <= s_tdata[119:104];
                        ports_reg <= (in_proto == PROTO_TCP || in_proto == PROTO_UDP ||
                                      in_proto == PROTO_SCTP) ?
                                     {s_tdata[87:72], s_tdata[103:88]} : '0;
                        marks_reg <= {s_tdata[126],
                                      (in_proto == PROTO_TCP) ? s_tdata[125:120] : 6'd0};
                        rd_cnt_reg   <= '0;
                        rd_pend_reg  <= 1'b0;
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        exp_any_reg  <= 1'b0;
                        if (s_tuser == KIND_TICK) begin
                            now_reg   <= now_reg + TIME_BITS'(1);
                            state_reg <= ST_SCAN;
                        end else if (enable_reg) begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        if (rd_pend_reg) begin
                            if (kind_reg == KIND_TICK) begin
                                if (rd_expire) begin
                                    // Another record follows, so the held one
                                    // goes out without tlast.
                                    valid_reg[chk_idx_reg] <= 1'b0;
                                    exp_ent_reg <= ram_rd;
                                    exp_any_reg <= 1'b1;
                                    if (exp_any_reg) begin
                                        m_valid_reg <= 1'b1;
                                        m_user_reg  <= STATUS_EXPORT;
                                        m_last_reg  <= 1'b0;
                                        m_data_reg  <= pack_rec(exp_ent_reg);
                                    end
                                end
                            end else begin
                                if (rd_match && !hit_reg) begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= chk_idx_reg;
                                    hit_ent_reg <= ram_rd;
                                end
                                if (!valid_reg[chk_idx_reg] && !free_reg) begin
                                    free_reg     <= 1'b1;
                                    free_idx_reg <= chk_idx_reg;
                                end
                            end
                        end
                        if (more_reads) begin
                            chk_idx_reg <= rd_cnt_reg[IDX_BITS-1:0];
                            rd_cnt_reg  <= rd_cnt_reg + CNT_BITS'(1);
                            rd_pend_reg <= 1'b1;
                        end else begin
                            rd_pend_reg <= 1'b0;
                            if (rd_pend_reg) begin
                                state_reg <= ST_DECIDE;
                            end
                        end
                    end
                end
                ST_DECIDE: begin
                    if (kind_reg == KIND_TICK) begin
                        // The held record is the last one of the run.
                        if (exp_any_reg) begin
                            if (out_free) begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= STATUS_EXPORT;
                                m_last_reg  <= 1'b1;
                                m_data_reg  <= pack_rec(exp_ent_reg);
                                exp_any_reg <= 1'b0;
                                state_reg   <= ST_IDLE;
                            end
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else if (hit_reg || free_reg) begin
                        state_reg <= ST_WRITE;
                    end else if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= STATUS_DROP;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= pack_rec(newent);
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_WRITE: begin
                    if (!hit_reg) begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ dv/fcwt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwt_checker
// Watches the item, record and register channels of the flow cache, keeps
// its own copy of the flow table and compares every record with the next
// expected one.
// ----------------------------------------------------------------------------
module fcwt_checker
    import fcwt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                      m_tuser,
    input  logic                      m_tlast,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        n_exports,
    output int                        n_drops
);

    localparam logic [47:0] BYTES_SAT = '1;
    localparam logic [31:0] PKTS_SAT  = '1;

    typedef struct {
        logic                 status;
        logic                 last;
        logic [31:0]          src;
        logic [31:0]          dst;
        logic [7:0]           proto;
        logic [15:0]          sport;
        logic [15:0]          dport;
        logic [TIME_BITS-1:0] t_first;
        logic [TIME_BITS-1:0] t_latest;
        logic [31:0]          pkts;
        logic [47:0]          nbytes;
        logic [6:0]           marks;
    } flow_rec_t;

    flow_rec_t record_q[$];

    logic                 tbl_valid [TABLE_ENTRIES];
    flow_rec_t            tbl       [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] now_t;
    logic                 en_r;
    logic [15:0]          idle_r;
    logic [15:0]          active_r;

    assign pending = record_q.size();

    task automatic predict_item(input logic kind, input logic [IN_TDATA_BITS-1:0] d);
        flow_rec_t r;
        int free_idx;
        int n;
        logic [48:0] sum;
        n = 0;
        free_idx = -1;
        if (kind == KIND_TICK) begin
            now_t = now_t + 1'b1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i] && ((TIME_BITS'(now_t - tbl[i].t_latest) >= idle_r) ||
                                     (TIME_BITS'(now_t - tbl[i].t_first) >= active_r))) begin
                    r = tbl[i];
                    r.status = STATUS_EXPORT;
                    r.last = 1'b0;
                    record_q.push_back(r);
                    tbl_valid[i] = 1'b0;
                    n++;
                end
            end
        end else if (en_r) begin
            r.src = d[31:0];
            r.dst = d[63:32];
            r.proto = d[71:64];
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (tbl[i].src == r.src && tbl[i].dst == r.dst &&
                        tbl[i].proto == r.proto) begin
                        if (tbl[i].pkts != PKTS_SAT) tbl[i].pkts++;
                        sum = {1'b0, tbl[i].nbytes} + d[119:104];
                        tbl[i].nbytes = sum[48] ? BYTES_SAT : sum[47:0];
                        tbl[i].t_latest = now_t;
                        return;
                    end
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            // Ports only for TCP, UDP and SCTP; flags only for TCP.
            if (r.proto == PROTO_TCP || r.proto == PROTO_UDP || r.proto == PROTO_SCTP) begin
                r.sport = d[87:72];
                r.dport = d[103:88];
            end else begin
                r.sport = '0;
                r.dport = '0;
            end
            r.marks = {d[126], (r.proto == PROTO_TCP) ? d[125:120] : 6'd0};
            r.t_first = now_t;
            r.t_latest = now_t;
            r.pkts = 1;
            r.nbytes = 48'(d[119:104]);
            r.last = 1'b0;
            if (free_idx < 0) begin
                r.status = STATUS_DROP;
                record_q.push_back(r);
                n = 1;
            end else begin
                tbl_valid[free_idx] = 1'b1;
                tbl[free_idx] = r;
            end
        end
        if (n > 0) record_q[$].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        flow_rec_t e;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            now_t = '0;
            en_r = 1'b0;
            idle_r = '0;
            active_r = '0;
            record_q.delete();
            errors = 0;
            n_exports = 0;
            n_drops = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE: en_r = cfg_data[0];
                    REG_IDLE:   idle_r = cfg_data[15:0];
                    REG_ACTIVE: active_r = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (record_q.size() == 0) begin
                    $error("record arrived with none expected");
                    errors++;
                end else begin
                    e = record_q.pop_front();
                    if (e.status == STATUS_DROP) n_drops++;
                    else n_exports++;
                    check_field("status", e.status, m_tuser);
                    check_field("last_of_run", e.last, m_tlast);
                    check_field("flow_src_ip", e.src, m_tdata[31:0]);
                    check_field("flow_dst_ip", e.dst, m_tdata[63:32]);
                    check_field("flow_protocol", e.proto, m_tdata[71:64]);
                    check_field("flow_src_port", e.sport, m_tdata[87:72]);
                    check_field("flow_dst_port", e.dport, m_tdata[103:88]);
                    check_field("first_tick", e.t_first, m_tdata[135:104]);
                    check_field("last_tick", e.t_latest, m_tdata[167:136]);
                    check_field("packets", e.pkts, m_tdata[199:168]);
                    check_field("bytes", e.nbytes, m_tdata[247:200]);
                    check_field("marks", e.marks, m_tdata[254:248]);
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the flow cache with idle and active timeouts.
// Directed items cover the protocol rules, disabled packets and immediate
// timeouts, a fill phase overflows the table and then exports all of it in
// one tick, and random phases mix packets of a small key pool with ticks
// under varied timeouts and flow control. A separate checker predicts and
// compares every record.
// ----------------------------------------------------------------------------
module testbench;
    import fcwt_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;  // no register behind this index
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int KEY_POOL = 12;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = '0;
    logic [31:0]               cfg_data = '0;

    int errors, pending, n_exports, n_drops;
    int gap_pct = 0;       // chance per cycle that the sender idles
    int stall_pct = 0;     // chance per cycle that the receiver stalls
    logic hold_go = 1'b0;  // asks the receiver for one long hold-off
    int items_sent = 0;
    int quiet_cycles = 0;

    logic [31:0] pool_src [KEY_POOL];
    logic [31:0] pool_dst [KEY_POOL];
    logic [7:0]  pool_proto [KEY_POOL];

    always #2 aclk = ~aclk;

    flow_cache_with_timeouts uut (.*);

    fcwt_checker checker_i (.*);

    // Receiver: random stalls, plus one long hold-off counted here so that
    // the block fills up and stops taking items.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_BITS-1:0] pack_packet(
        input logic [31:0] src, input logic [31:0] dst, input logic [7:0] proto,
        input logic [15:0] sport, input logic [15:0] dport, input logic [15:0] len,
        input logic [5:0] flags, input logic tag);
        return {1'b0, tag, flags, len, dport, sport, proto, dst, src};
    endfunction

    // Offers one item, with random idle cycles ahead of it, and waits for it
    // to be taken.
    task automatic send(input logic kind, input logic [IN_TDATA_BITS-1:0] d);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_packet(input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] proto);
        send(KIND_PACKET, pack_packet(src, dst, proto, 16'($urandom), 16'($urandom),
                                      16'($urandom), 6'($urandom), 1'($urandom)));
    endtask

    task automatic send_tick();
        send(KIND_TICK, {$urandom, $urandom, $urandom, $urandom});
    endtask

    // Pauses the sender until every expected record has come and the block
    // has had time to finish a packet sweep, then goes on.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only ever happen with the block idle. Upper data bits
    // are random since the block must ignore them.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {16'($urandom), (idx == REG_ENABLE) ? {15'($urandom), value[0]} : value};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timeouts(input logic enable, input logic [15:0] idle_t,
                                input logic [15:0] active_t);
        settle();
        write_reg(REG_ENABLE, {15'd0, enable});
        write_reg(REG_IDLE, idle_t);
        write_reg(REG_ACTIVE, active_t);
    endtask

    initial begin
        int k;
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_src[i] = $urandom;
            pool_dst[i] = $urandom;
            case (i % 4)
                0: pool_proto[i] = PROTO_TCP;
                1: pool_proto[i] = PROTO_UDP;
                2: pool_proto[i] = PROTO_SCTP;
                default: pool_proto[i] = 8'($urandom);
            endcase
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Packets are ignored while the block is disabled,
        // and a tick over an empty table gives nothing.
        send_packet(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP);
        send_tick();
        settle();
        write_reg(REG_UNUSED, 16'hFFFF);

        // Zero timeouts: everything opened is exported on the next tick.
        set_timeouts(1'b1, 16'd0, 16'd0);
        send(KIND_PACKET, pack_packet('1, '1, PROTO_TCP, '1, '1, '1, '1, 1'b1));
        send(KIND_PACKET, pack_packet('1, '1, PROTO_TCP, 16'd1, 16'd2, '1, 6'd0, 1'b0));
        send(KIND_PACKET, pack_packet('0, '0, PROTO_UDP, '0, '0, '0, '0, 1'b0));
        send(KIND_PACKET, pack_packet(32'h1, 32'h2, PROTO_SCTP, 16'h8000, 16'h1, 16'd64,
                                      6'h3F, 1'b0));
        send(KIND_PACKET, pack_packet(32'h3, 32'h4, 8'd0, '1, '1, 16'd40, '1, 1'b1));
        send(KIND_PACKET, pack_packet(32'h3, 32'h4, 8'hFF, 16'h1234, 16'h5678, 16'd9,
                                      6'h15, 1'b0));
        send_tick();

        // Small timeouts, and a key that comes back after its first flow
        // ended, so an old active deadline must not cut the new flow short.
        set_timeouts(1'b1, 16'd2, 16'd3);
        send_packet(32'hC0A8_0001, 32'hC0A8_0002, PROTO_TCP);
        send_tick();
        send_packet(32'hC0A8_0001, 32'hC0A8_0002, PROTO_TCP);
        send_tick();
        send_tick();
        send_packet(32'hC0A8_0001, 32'hC0A8_0002, PROTO_TCP);
        send_tick();
        send_packet(32'hC0A8_0001, 32'hC0A8_0002, PROTO_TCP);
        send_tick();
        send_tick();
        send_tick();

        // Fill the table with long timeouts; the last new flows are dropped.
        set_timeouts(1'b1, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < TABLE_ENTRIES + 3; i++)
            send_packet($urandom, 32'(i), 8'($urandom));
        send_packet(pool_src[0], pool_dst[0], pool_proto[0]);
        send_tick();
        // Dropping the idle timeout to zero exports the whole table at once.
        set_timeouts(1'b1, 16'd0, 16'hFFFF);
        send_tick();

        // Random phases under each flow-control pattern.
        for (int p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 62; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 6; stall_pct = 6; end
            endcase
            if (p == 1)
                set_timeouts(1'b1, 16'd0, 16'd1);
            else if (p == 4)
                set_timeouts(1'b0, 16'($urandom_range(1, 4)), 16'($urandom_range(2, 8)));
            else
                set_timeouts(1'b1, 16'($urandom_range(1, 6)), 16'($urandom_range(2, 12)));
            if (p == 1) hold_go <= 1'b1;
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(99) < 28) begin
                    send_tick();
                end else if ($urandom_range(99) < 85) begin
                    k = $urandom_range(KEY_POOL - 1);
                    send_packet(pool_src[k], pool_dst[k], pool_proto[k]);
                end else begin
                    send_packet($urandom, $urandom, 8'($urandom));
                end
            end
        end

        // Flush whatever is left so every flow is checked once more.
        set_timeouts(1'b1, 16'd0, 16'd0);
        send_tick();

        s_tvalid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items; checked %0d exported flows and %0d dropped flows.",
                 items_sent, n_exports, n_drops);
        $display("Covered disabled packets, full table, zero and maximum timeouts.");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ flow_cache_with_timeouts.f @@
src/fcwt_pkg.sv
src/fcwt_ram.sv
src/flow_cache_with_timeouts.sv
dv/fcwt_checker.sv
dv/testbench.sv
